[sv/ppv2_pkg.sv]
// Shared types, constants and helpers for the PROXY v2 binary header parser.
package ppv2_pkg;

  localparam int CNT_W = 17;

  localparam logic [CNT_W-1:0] SIG_LEN   = 17'd12;
  localparam logic [CNT_W-1:0] VC_IDX    = 17'd12;
  localparam logic [CNT_W-1:0] FP_IDX    = 17'd13;
  localparam logic [CNT_W-1:0] FIXED_LEN = 17'd16;

  localparam logic [CNT_W-1:0] V4_SRC_END  = 17'd4;
  localparam logic [CNT_W-1:0] V4_DST_END  = 17'd8;
  localparam logic [CNT_W-1:0] V4_PORT_END = 17'd12;
  localparam logic [CNT_W-1:0] V6_SRC0_END = 17'd8;
  localparam logic [CNT_W-1:0] V6_SRC1_END = 17'd16;
  localparam logic [CNT_W-1:0] V6_DST0_END = 17'd24;
  localparam logic [CNT_W-1:0] V6_DST1_END = 17'd32;
  localparam logic [CNT_W-1:0] V6_PORT_END = 17'd36;

  localparam logic [15:0] V4_BODY = 16'd12;
  localparam logic [15:0] V6_BODY = 16'd36;

  localparam logic [7:0] FAM_TCP4 = 8'h11;
  localparam logic [7:0] FAM_UDP4 = 8'h12;
  localparam logic [7:0] FAM_TCP6 = 8'h21;
  localparam logic [7:0] FAM_UDP6 = 8'h22;
  localparam logic [3:0] CMD_LOCAL = 4'h0;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TRUNCATED   = 3'd1,
    ST_BAD_SIG     = 3'd2,
    ST_SHORT       = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    AF_LOCAL = 2'd0,
    AF_IPV4  = 2'd1,
    AF_IPV6  = 2'd2
  } family_t;

  // Fixed 12-byte signature at the head of every header
  function automatic logic [7:0] sig_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0:    b = 8'h0d;
      4'd1:    b = 8'h0a;
      4'd2:    b = 8'h0d;
      4'd3:    b = 8'h0a;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h0d;
      4'd6:    b = 8'h0a;
      4'd7:    b = 8'h51;
      4'd8:    b = 8'h55;
      4'd9:    b = 8'h49;
      4'd10:   b = 8'h54;
      4'd11:   b = 8'h0a;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic fam_is_v4(input logic [7:0] f);
    return (f == FAM_TCP4) || (f == FAM_UDP4);
  endfunction

  function automatic logic fam_is_v6(input logic [7:0] f);
    return (f == FAM_TCP6) || (f == FAM_UDP6);
  endfunction

endpackage

[sv/proxy_v2_binary_header_parser.sv]
// PROXY v2 binary header parser: byte-serial capture, checks and one result per buffer.
// Throughput: one byte per cycle, sustained, while results are taken.
// A result is registered and presented the cycle after its last byte is accepted;
// the single result register holds it until taken, and byte_stall is raised only while a
// held result is itself stalled.
// Reset (rst, synchronous): returns the parser to the start of a buffer and drops any
// pending result.
module proxy_v2_binary_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [1:0]  addr_family,
  output logic [63:0] src_addr_upper,
  output logic [63:0] src_addr_lower,
  output logic [63:0] dst_addr_upper,
  output logic [63:0] dst_addr_lower,
  output logic [15:0] src_l4_port,
  output logic [15:0] dst_l4_port
);
  import ppv2_pkg::*;

  // Parser state
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             signature_ok, signature_ok_next;
  logic [7:0]       version_command, version_command_next;
  logic [7:0]       family_protocol, family_protocol_next;
  logic [15:0]      body_length, body_length_next;
  logic [63:0]      src_hi, src_hi_next, src_lo, src_lo_next;
  logic [63:0]      dst_hi, dst_hi_next, dst_lo, dst_lo_next;
  logic [31:0]      port_pair, port_pair_next;
  logic             result_given, result_given_next;

  // Result computed for this beat
  logic             hit;
  status_t          res_status;
  family_t          res_family;
  logic             res_addr;
  logic [CNT_W-1:0] body_off;
  logic [CNT_W-1:0] end_count;
  logic             byte_acc;

  assign byte_stall = result_valid && result_stall;
  assign byte_acc   = byte_valid && !byte_stall;
  assign body_off   = byte_count - FIXED_LEN;

  // Capture, count and decide on the current byte
  always_comb begin
    byte_count_next      = byte_count;
    signature_ok_next    = signature_ok;
    version_command_next = version_command;
    family_protocol_next = family_protocol;
    body_length_next     = body_length;
    src_hi_next          = src_hi;
    src_lo_next          = src_lo;
    dst_hi_next          = dst_hi;
    dst_lo_next          = dst_lo;
    port_pair_next       = port_pair;
    result_given_next    = result_given;
    hit                  = 1'b0;
    res_status           = ST_OK;
    res_family           = AF_LOCAL;
    res_addr             = 1'b0;
    end_count            = '0;

    if (!result_given) begin
      priority if (byte_count < SIG_LEN) begin
        if (data_byte != sig_byte(byte_count[3:0])) signature_ok_next = 1'b0;
      end else if (byte_count == VC_IDX) begin
        version_command_next = data_byte;
      end else if (byte_count == FP_IDX) begin
        family_protocol_next = data_byte;
      end else if (byte_count < FIXED_LEN) begin
        body_length_next = {body_length[7:0], data_byte};
      end else if (fam_is_v4(family_protocol)) begin
        // IPv4 block: 4 source, 4 destination, 4 port bytes
        priority if (body_off < V4_SRC_END) begin
          src_lo_next = {32'h0, src_lo[23:0], data_byte};
        end else if (body_off < V4_DST_END) begin
          dst_lo_next = {32'h0, dst_lo[23:0], data_byte};
        end else if (body_off < V4_PORT_END) begin
          port_pair_next = {port_pair[23:0], data_byte};
        end else begin
          port_pair_next = port_pair;
        end
      end else begin
        // IPv6 layout, also used for any other family
        priority if (body_off < V6_SRC0_END) begin
          src_hi_next = {src_hi[55:0], data_byte};
        end else if (body_off < V6_SRC1_END) begin
          src_lo_next = {src_lo[55:0], data_byte};
        end else if (body_off < V6_DST0_END) begin
          dst_hi_next = {dst_hi[55:0], data_byte};
        end else if (body_off < V6_DST1_END) begin
          dst_lo_next = {dst_lo[55:0], data_byte};
        end else if (body_off < V6_PORT_END) begin
          port_pair_next = {port_pair[23:0], data_byte};
        end else begin
          port_pair_next = port_pair;
        end
      end

      byte_count_next = byte_count + 17'd1;
      end_count       = FIXED_LEN + {1'b0, body_length_next};

      priority if (byte_count_next == FIXED_LEN && !signature_ok_next) begin
        hit        = 1'b1;
        res_status = ST_BAD_SIG;
      end else if (byte_count_next >= FIXED_LEN && byte_count_next == end_count) begin
        hit = 1'b1;
        priority if (fam_is_v4(family_protocol_next)) begin
          if (body_length_next < V4_BODY) begin
            res_status = ST_SHORT;
          end else begin
            res_family = AF_IPV4;
            res_addr   = 1'b1;
          end
        end else if (fam_is_v6(family_protocol_next)) begin
          if (body_length_next < V6_BODY) begin
            res_status = ST_SHORT;
          end else begin
            res_family = AF_IPV6;
            res_addr   = 1'b1;
          end
        end else if (version_command_next[3:0] == CMD_LOCAL) begin
          res_status = ST_OK;
        end else begin
          res_status = ST_UNSUPPORTED;
        end
      end else if (end_of_buffer) begin
        hit        = 1'b1;
        res_status = ST_TRUNCATED;
      end else begin
        hit = 1'b0;
      end

      if (hit) result_given_next = 1'b1;
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      signature_ok    <= 1'b1;
      version_command <= '0;
      family_protocol <= '0;
      body_length     <= '0;
      src_hi          <= '0;
      src_lo          <= '0;
      dst_hi          <= '0;
      dst_lo          <= '0;
      port_pair       <= '0;
      result_given    <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;

      if (byte_acc) begin
        if (end_of_buffer) begin
          byte_count      <= '0;
          signature_ok    <= 1'b1;
          version_command <= '0;
          family_protocol <= '0;
          body_length     <= '0;
          src_hi          <= '0;
          src_lo          <= '0;
          dst_hi          <= '0;
          dst_lo          <= '0;
          port_pair       <= '0;
          result_given    <= 1'b0;
        end else begin
          byte_count      <= byte_count_next;
          signature_ok    <= signature_ok_next;
          version_command <= version_command_next;
          family_protocol <= family_protocol_next;
          body_length     <= body_length_next;
          src_hi          <= src_hi_next;
          src_lo          <= src_lo_next;
          dst_hi          <= dst_hi_next;
          dst_lo          <= dst_lo_next;
          port_pair       <= port_pair_next;
          result_given    <= result_given_next;
        end

        if (hit) begin
          result_valid   <= 1'b1;
          status         <= res_status;
          addr_family    <= res_family;
          src_addr_upper <= (res_addr && res_family == AF_IPV6) ? src_hi_next : 64'h0;
          src_addr_lower <= res_addr ? src_lo_next : 64'h0;
          dst_addr_upper <= (res_addr && res_family == AF_IPV6) ? dst_hi_next : 64'h0;
          dst_addr_lower <= res_addr ? dst_lo_next : 64'h0;
          src_l4_port    <= res_addr ? port_pair_next[31:16] : 16'h0;
          dst_l4_port    <= res_addr ? port_pair_next[15:0] : 16'h0;
        end
      end
    end
  end

  // Checks
  a_stall_only_on_held: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (result_valid && result_stall))
    else $error("byte_stall raised without a stalled result");

  a_error_no_addr: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_OK) |->
      (addr_family == AF_LOCAL && src_addr_lower == 64'h0 && dst_l4_port == 16'h0))
    else $error("error result carries address data");

  a_buffer_end_restart: assert property (@(posedge clk) disable iff (rst)
    (byte_acc && end_of_buffer) |=> (byte_count == '0 && !result_given && signature_ok))
    else $error("parser not back at buffer start after final byte");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (byte_acc && result_given) |-> !hit)
    else $error("second result raised within one buffer");

endmodule
